FILE: rtl/rkxf_pkg.sv
// ----------------------------------------------------------------------------
// rkxf_pkg
// Shared types and constants for the rotating key XOR framer.
// ----------------------------------------------------------------------------
package rkxf_pkg;

    localparam int KEY_W  = 32;
    localparam int LEN_W  = 32;
    localparam int BYTE_W = 8;
    localparam int STEP_W = 3;
    localparam int POS_W  = 2;

    // Byte slots of a start item: four key bytes, then four length bytes.
    localparam logic [STEP_W-1:0] STEP_KEY0 = 3'd0;
    localparam logic [STEP_W-1:0] STEP_LEN0 = 3'd4;
    localparam logic [STEP_W-1:0] STEP_LAST = 3'd7;

    typedef enum logic [0:0] {
        OP_START   = 1'b0,
        OP_PAYLOAD = 1'b1
    } op_t;

    // One byte handed from the sequencer to the cipher stage.
    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] raw;
        logic              encode;
        logic              load_key;
        logic [KEY_W-1:0]  key_word;
        logic              last;
    } byte_req_t;

endpackage

FILE: rtl/rkxf_seq.sv
// ----------------------------------------------------------------------------
// rkxf_seq
// Input register and byte sequencer: holds one item and walks its bytes.
// ----------------------------------------------------------------------------
module rkxf_seq (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                obf_en,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  rkxf_pkg::op_t                       in_op,
    input  logic [rkxf_pkg::KEY_W-1:0]          in_key,
    input  logic [rkxf_pkg::LEN_W-1:0]          in_len,
    input  logic [rkxf_pkg::BYTE_W-1:0]         in_data,
    input  logic                                slot_free,
    output rkxf_pkg::byte_req_t                 req
);

    logic                          valid_reg, valid_next;
    logic                          first_reg, first_next;
    logic [rkxf_pkg::STEP_W-1:0]   step_reg, step_next;
    rkxf_pkg::op_t                 op_reg, op_next;
    logic [rkxf_pkg::KEY_W-1:0]    key_reg, key_next;
    logic [rkxf_pkg::LEN_W-1:0]    len_reg, len_next;
    logic [rkxf_pkg::BYTE_W-1:0]   data_reg, data_next;

    logic emit;
    logic emit_last;
    logic accept;

    assign emit      = valid_reg && slot_free;
    assign emit_last = (op_reg == rkxf_pkg::OP_PAYLOAD) || (step_reg == rkxf_pkg::STEP_LAST);
    // The held item leaves on its last byte, so a new one can enter that cycle.
    assign in_ready  = !valid_reg || (emit && emit_last);
    assign accept    = in_valid && in_ready;

    always_comb
    begin
        valid_next = valid_reg;
        first_next = first_reg;
        step_next  = step_reg;
        op_next    = op_reg;
        key_next   = key_reg;
        len_next   = len_reg;
        data_next  = data_reg;
        if (emit)
        begin
            first_next = 1'b0;
            step_next  = rkxf_pkg::STEP_W'(step_reg + 3'd1);
            if (emit_last)
            begin
                valid_next = 1'b0;
            end
        end
        if (accept)
        begin
            valid_next = 1'b1;
            first_next = 1'b1;
            op_next    = in_op;
            key_next   = in_key;
            len_next   = in_len;
            data_next  = in_data;
            // Plain start items skip the key bytes.
            step_next  = (in_op == rkxf_pkg::OP_START && !obf_en) ?
                         rkxf_pkg::STEP_LEN0 : rkxf_pkg::STEP_KEY0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            first_reg <= 1'b0;
            step_reg  <= rkxf_pkg::STEP_KEY0;
        end
        else
        begin
            valid_reg <= valid_next;
            first_reg <= first_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        key_reg  <= key_next;
        len_reg  <= len_next;
        data_reg <= data_next;
    end

    always_comb
    begin
        req.valid    = emit;
        req.last     = emit_last;
        req.key_word = key_reg;
        req.load_key = (op_reg == rkxf_pkg::OP_START) && first_reg;
        if (op_reg == rkxf_pkg::OP_PAYLOAD)
        begin
            req.raw    = data_reg;
            req.encode = obf_en;
        end
        else if (!step_reg[2])
        begin
            req.raw    = key_reg[{step_reg[1:0], 3'b000} +: rkxf_pkg::BYTE_W];
            req.encode = 1'b0;
        end
        else
        begin
            req.raw    = len_reg[{step_reg[1:0], 3'b000} +: rkxf_pkg::BYTE_W];
            req.encode = obf_en;
        end
    end

`ifndef SYNTHESIS
    a_payload_single: assert property (@(posedge clk) disable iff (!rst_n)
        emit && op_reg == rkxf_pkg::OP_PAYLOAD |-> first_reg)
        else $error("payload item emitted more than one byte");

    a_take_frees_slot: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && in_ready |-> slot_free && emit_last)
        else $error("new item taken while held item still has bytes");

    a_step_advance: assert property (@(posedge clk) disable iff (!rst_n)
        emit && !emit_last && !accept |=> valid_reg && step_reg == $past(step_reg) + 3'd1)
        else $error("start item byte slot did not advance");
`endif

endmodule

FILE: rtl/rkxf_cipher.sv
// ----------------------------------------------------------------------------
// rkxf_cipher
// Rotating key state and the byte XOR applied to encoded stream bytes.
// ----------------------------------------------------------------------------
module rkxf_cipher (
    input  logic                            clk,
    input  logic                            rst_n,
    input  rkxf_pkg::byte_req_t             req,
    output logic [rkxf_pkg::BYTE_W-1:0]     enc_byte
);

    logic [rkxf_pkg::KEY_W-1:0] key_reg, key_next;
    logic [rkxf_pkg::POS_W-1:0] pos_reg, pos_next;
    logic [rkxf_pkg::KEY_W-1:0] rot_key;
    logic [rkxf_pkg::BYTE_W-1:0] key_byte;

    always_comb
    begin
        // A rotate right by 31 is a rotate left by one; it happens on byte zero.
        rot_key  = (pos_reg == '0) ?
                   {key_reg[rkxf_pkg::KEY_W-2:0], key_reg[rkxf_pkg::KEY_W-1]} : key_reg;
        key_byte = rot_key[{pos_reg, 3'b000} +: rkxf_pkg::BYTE_W];
        enc_byte = req.encode ? (req.raw ^ key_byte) : req.raw;

        key_next = key_reg;
        pos_next = pos_reg;
        if (req.valid && req.load_key)
        begin
            key_next = req.key_word;
            pos_next = '0;
        end
        else if (req.valid && req.encode)
        begin
            key_next = rot_key;
            pos_next = rkxf_pkg::POS_W'(pos_reg + 2'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
            pos_reg <= '0;
        end
        else
        begin
            key_reg <= key_next;
            pos_reg <= pos_next;
        end
    end

`ifndef SYNTHESIS
    a_load_not_encoded: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.load_key |-> !req.encode)
        else $error("key load coincides with an encoded byte");

    a_key_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.load_key |=> key_reg == $past(req.key_word) && pos_reg == '0)
        else $error("key register not loaded from start item");
`endif

endmodule

FILE: rtl/rotating_key_xor_framer_top.sv
// Each accepted item is held in the input register, its bytes in the output register.
// Payload items run at one per cycle while the output does not stall; a start item holds
// the input while it sends eight bytes with obfuscation on and four with it off, one
// byte per cycle through the single output register while the output does not stall.
// Reset (rst_n, asynchronous, active low) clears the mode, the key, the byte
// position and all valid flags.
// ----------------------------------------------------------------------------
// rotating_key_xor_framer_top
// Frames key/length-headed messages; with obfuscation on, XORs them with a rotating key.
// ----------------------------------------------------------------------------
module rotating_key_xor_framer_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,          // obfuscate_enable
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,       // key_word[31:0], message_length[63:32],
                                            // data_byte[71:64]
    input  logic        s_axis_tuser,       // operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,       // out_byte[7:0]
    output logic        m_axis_tlast        // last_of_run
);

    logic                          obf_reg, obf_next;
    logic                          out_valid_reg, out_valid_next;
    logic [rkxf_pkg::BYTE_W-1:0]   out_byte_reg, out_byte_next;
    logic                          out_last_reg, out_last_next;
    logic                          slot_free;
    logic [rkxf_pkg::BYTE_W-1:0]   enc_byte;
    rkxf_pkg::byte_req_t           req;

    assign slot_free = !out_valid_reg || m_axis_tready;

    rkxf_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .obf_en    (obf_reg),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_op     (rkxf_pkg::op_t'(s_axis_tuser)),
        .in_key    (s_axis_tdata[31:0]),
        .in_len    (s_axis_tdata[63:32]),
        .in_data   (s_axis_tdata[71:64]),
        .slot_free (slot_free),
        .req       (req)
    );

    rkxf_cipher u_cipher (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .enc_byte (enc_byte)
    );

    always_comb
    begin
        obf_next       = cfg_we ? cfg_wdata : obf_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        if (req.valid)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = enc_byte;
            out_last_next  = req.last;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            obf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            obf_reg       <= obf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_byte_reg;
    assign m_axis_tlast  = out_last_reg;

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |-> !req.valid)
        else $error("result register overwritten while stalled");

    a_last_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && !req.last |-> !s_axis_tready)
        else $error("input ready while a start item still has bytes");
`endif

endmodule

FILE: tb/rkxf_checker.sv
// ----------------------------------------------------------------------------
// rkxf_checker
// Watches the framer's input, output and mode-write ports. Each accepted input
// word is expanded into the bytes the framer should produce. Each accepted
// output word is compared against the oldest of those bytes.
// ----------------------------------------------------------------------------
module rkxf_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,       // key_word[31:0], message_length[63:32],
                                            // data_byte[71:64]
    input  logic        s_axis_tuser,       // operation
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [7:0]  m_axis_tdata,       // out_byte[7:0]
    input  logic        m_axis_tlast,       // last_of_run
    output int          fail_count,
    output int          pending
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [rkxf_pkg::BYTE_W-1:0] out_byte;
        logic                        last;
    } framed_byte_t;

    framed_byte_t                framed_bytes[$];
    logic                        scramble_on;
    logic [rkxf_pkg::KEY_W-1:0]  rolling_key;
    logic [rkxf_pkg::POS_W-1:0]  stream_pos;

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
        fail_count++;
    endtask

    // The key turns left by one bit whenever the stream reaches a word boundary.
    task automatic scramble(inout logic [rkxf_pkg::BYTE_W-1:0] b);
        if (stream_pos == '0)
            rolling_key = {rolling_key[rkxf_pkg::KEY_W-2:0],
                           rolling_key[rkxf_pkg::KEY_W-1]};
        b = b ^ rolling_key[stream_pos*8 +: 8];
        stream_pos = stream_pos + 1'b1;
    endtask

    task automatic frame_word(input rkxf_pkg::op_t op,
                              input logic [rkxf_pkg::KEY_W-1:0] key,
                              input logic [rkxf_pkg::LEN_W-1:0] len,
                              input logic [rkxf_pkg::BYTE_W-1:0] data);
        logic [rkxf_pkg::BYTE_W-1:0] b;
        if (op == rkxf_pkg::OP_START) begin
            rolling_key = key;
            stream_pos  = '0;
            if (scramble_on) begin
                for (int i = 0; i < 4; i++)
                    framed_bytes.push_back('{key[8*i +: 8], 1'b0});
            end
            for (int i = 0; i < 4; i++) begin
                b = len[8*i +: 8];
                if (scramble_on)
                    scramble(b);
                framed_bytes.push_back('{b, i == 3});
            end
        end
        else begin
            b = data;
            if (scramble_on)
                scramble(b);
            framed_bytes.push_back('{b, 1'b1});
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        framed_byte_t want;
        if (!rst_n)
        begin
            framed_bytes.delete();
            scramble_on = 1'b0;
            rolling_key = '0;
            stream_pos  = '0;
            fail_count  = 0;
            pending    <= 0;
        end
        else
        begin
            // Outputs first: a word accepted at this edge cannot have caused
            // a byte that leaves at the same edge.
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (framed_bytes.size() == 0)
                    report_mismatch("unexpected output word", m_axis_tdata, 8'h00);
                else
                begin
                    want = framed_bytes.pop_front();
                    if (m_axis_tdata !== want.out_byte)
                        report_mismatch("out_byte", m_axis_tdata, want.out_byte);
                    if (m_axis_tlast !== want.last)
                        report_mismatch("last_of_run", {7'd0, m_axis_tlast},
                                        {7'd0, want.last});
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                frame_word(rkxf_pkg::op_t'(s_axis_tuser), s_axis_tdata[31:0],
                           s_axis_tdata[63:32], s_axis_tdata[71:64]);
            // A mode write counts from the next word on.
            if (cfg_we)
                scramble_on = cfg_wdata;
            pending <= framed_bytes.size();
        end
    end

endmodule

FILE: tb/rotating_key_xor_framer_top_tb.sv
// ----------------------------------------------------------------------------
// rotating_key_xor_framer_top_tb
// Drives start and payload words into the framer in both modes, with idle
// and stall phases on either side, and takes the verdict from the checker.
// ----------------------------------------------------------------------------
module rotating_key_xor_framer_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;
    int          fail_count;
    int          pending;

    int          sender_idle_pct;
    int          sink_stall_pct;
    int          words_sent;

    rotating_key_xor_framer_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    rkxf_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // Sink side: stall at the rate of the current phase.
    initial
    begin
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    // Holds the word until it is taken. tvalid stays high afterwards, so the
    // next word can follow back to back; drain() drops it.
    task automatic send_word(input rkxf_pkg::op_t op, input logic [31:0] key,
                             input logic [31:0] len, input logic [7:0] data);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {data, len, key};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        words_sent++;
    endtask

    task automatic send_start(input logic [31:0] key, input logic [31:0] len);
        send_word(rkxf_pkg::OP_START, key, len, 8'($urandom));
    endtask

    task automatic send_payload(input logic [7:0] data);
        send_word(rkxf_pkg::OP_PAYLOAD, $urandom, $urandom, data);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic set_mode(input logic scramble);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= scramble;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    // Mostly well-formed messages (payload count equal to the header length),
    // some with a full-range length and a short body, some overrunning.
    task automatic run_messages(input int n_words);
        int          stop_at;
        logic [31:0] key;
        logic [31:0] len;
        int          body;
        stop_at = words_sent + n_words;
        while (words_sent < stop_at)
        begin
            if ($urandom_range(0, 9) == 0)
                set_mode(1'($urandom_range(0, 1)));
            case ($urandom_range(0, 9))
                0:       key = 32'h0000_0000;
                1:       key = 32'hffff_ffff;
                default: key = $urandom;
            endcase
            if ($urandom_range(0, 4) == 0)
            begin
                len  = $urandom;
                body = $urandom_range(0, 3);
            end
            else
            begin
                len  = $urandom_range(0, 10);
                body = len;
                if ($urandom_range(0, 9) == 0)
                    body += $urandom_range(1, 3);
            end
            send_start(key, len);
            for (int i = 0; i < body; i++)
                send_payload(8'($urandom_range(0, 255)));
        end
    endtask

    initial
    begin
        rst_n           <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_wdata       <= 1'b0;
        s_axis_tvalid   <= 1'b0;
        s_axis_tdata    <= '0;
        s_axis_tuser    <= 1'b0;
        sender_idle_pct  = 0;
        sink_stall_pct   = 0;
        words_sent       = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Plain payload right after reset passes through untouched.
        send_payload(8'h00);
        send_payload(8'hff);
        // Scrambled payload before any start uses the zero key.
        set_mode(1'b1);
        send_payload(8'ha5);
        send_start(32'hffff_ffff, 32'h0000_0000);
        send_start(32'h0000_0000, 32'hffff_ffff);
        send_payload(8'hff);
        // Payload runs past a word boundary, so the key turns again.
        send_start(32'h8000_0001, 32'h1234_5678);
        for (int i = 0; i < 6; i++)
            send_payload(8'($urandom_range(0, 255)));
        // More payload than the header announced.
        send_start(32'h0123_4567, 32'h0000_0001);
        for (int i = 0; i < 3; i++)
            send_payload(8'($urandom_range(0, 255)));
        // Mode flips mid-message; plain bytes leave the key stream alone.
        set_mode(1'b0);
        send_payload(8'h3c);
        set_mode(1'b1);
        send_payload(8'hc3);
        send_payload(8'h5a);
        // A plain start still loads the key for later scrambled payload.
        set_mode(1'b0);
        send_start(32'hdead_beef, 32'h0000_0002);
        send_payload(8'h11);
        set_mode(1'b1);
        send_payload(8'h22);
        send_payload(8'h33);

        sender_idle_pct = 0;
        sink_stall_pct  = 0;
        run_messages(15);

        set_mode(1'b0);
        sender_idle_pct = 58;
        sink_stall_pct  = 0;
        run_messages(15);

        set_mode(1'b1);
        sender_idle_pct = 0;
        sink_stall_pct  = 58;
        run_messages(8);
        drain();
        run_messages(7);

        sender_idle_pct = 14;
        sink_stall_pct  = 14;
        run_messages(15);

        drain();
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: sim.f
rtl/rkxf_pkg.sv
rtl/rkxf_seq.sv
rtl/rkxf_cipher.sv
rtl/rotating_key_xor_framer_top.sv
tb/rkxf_checker.sv
tb/rotating_key_xor_framer_top_tb.sv
